/* rtl/lgdr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lgdr_pkg;

  localparam int GridCount = 6;
  localparam int CountW    = $clog2(GridCount + 1);

  localparam logic [1:0] KindSet  = 2'd0;
  localparam logic [1:0] KindTick = 2'd1;
  localparam logic [1:0] KindFill = 2'd2;

  localparam logic [7:0] CmdAddr   = 8'hC0;
  localparam logic [7:0] CmdDispOn = 8'h88;
  localparam logic [7:0] CmdFixed  = 8'h44;
  localparam logic [7:0] CmdAuto   = 8'h40;
  localparam logic [7:0] ByteOn    = 8'hFF;
  localparam logic [7:0] ByteOff   = 8'h00;

  localparam logic [CountW-1:0] FixedCap = CountW'(3);

  localparam logic [0:0] RegBrightness = 1'd0;
  localparam logic [0:0] RegFixedLimit = 1'd1;

  localparam logic [2:0] BrightnessReset = 3'd7;
  localparam logic [2:0] FixedLimitReset = 3'd2;

  // datapath operations issued by the controller
  localparam logic [2:0] OpNone = 3'd0;
  localparam logic [2:0] OpMode = 3'd1;
  localparam logic [2:0] OpAddr = 3'd2;
  localparam logic [2:0] OpData = 3'd3;
  localparam logic [2:0] OpDisp = 3'd4;

  typedef struct packed {
    logic       accept;
    logic [2:0] op;
  } lgdr_cmd_t;

  typedef struct packed {
    logic write_req;
    logic count_zero;
    logic seq_done;
    logic fixed;
  } lgdr_stat_t;

endpackage

`default_nettype wire

/* rtl/lgdr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgdr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire lgdr_pkg::lgdr_stat_t stat,
  output lgdr_pkg::lgdr_cmd_t     cmd,
  output logic                    busy
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SMode = 3'd1;
  localparam logic [2:0] SAddr = 3'd2;
  localparam logic [2:0] SData = 3'd3;
  localparam logic [2:0] SDisp = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.accept = 1'b0;
    cmd.op     = lgdr_pkg::OpNone;
    unique case (state)
      SIdle: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (stat.write_req) begin
            state_next = SMode;
          end
        end
      end
      SMode: begin
        cmd.op = lgdr_pkg::OpMode;
        state_next = stat.count_zero ? SIdle : SAddr;
      end
      SAddr: begin
        cmd.op = lgdr_pkg::OpAddr;
        state_next = SData;
      end
      SData: begin
        cmd.op = lgdr_pkg::OpData;
        // auto-increment sends one address, then every grid byte in a row
        if (stat.seq_done) begin
          state_next = SDisp;
        end else begin
          state_next = stat.fixed ? SAddr : SData;
        end
      end
      SDisp: begin
        cmd.op = lgdr_pkg::OpDisp;
        state_next = SIdle;
      end
      default: begin
        state_next = SIdle;
      end
    endcase
  end

  assign busy = (state != SIdle);

endmodule

`default_nettype wire

/* rtl/lgdr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgdr_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lgdr_pkg::lgdr_cmd_t  cmd,
  output lgdr_pkg::lgdr_stat_t      stat,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [2:0]           cfg_data,
  input  wire logic [1:0]           kind,
  input  wire logic [2:0]           grid_index,
  input  wire logic [2:0]           segment_index,
  input  wire logic                 segment_on,
  output logic                      strobe,
  output logic [7:0]                bus_byte,
  output logic                      start_before,
  output logic                      stop_after,
  output logic                      last
);

  localparam int GridCount = lgdr_pkg::GridCount;
  localparam int CountW    = lgdr_pkg::CountW;

  logic [7:0]           shadow [GridCount];
  logic [GridCount-1:0] dirty_mask;
  logic                 pending;
  logic [2:0]           brightness;
  logic [2:0]           fixed_limit;
  logic                 fixed_mode;
  logic [GridCount-1:0] work_mask;
  logic [2:0]           grid_cnt;

  logic [CountW-1:0]    dirty_count;
  logic [2:0]           low_grid;
  logic [2:0]           cur_grid;
  logic [2:0]           rd_grid;
  logic [7:0]           rd_byte;
  logic                 grid_ok;
  logic [7:0]           seg_bit;
  logic [7:0]           edit_byte;
  logic                 use_fixed;
  logic [GridCount-1:0] work_mask_next;

  always_comb begin
    dirty_count = '0;
    for (int g = 0; g < GridCount; g++) begin
      dirty_count = dirty_count + CountW'(dirty_mask[g]);
    end
  end

  // lowest dirty grid still to send in fixed-address mode
  always_comb begin
    low_grid = '0;
    for (int g = GridCount - 1; g >= 0; g--) begin
      if (work_mask[g]) begin
        low_grid = 3'(g);
      end
    end
  end

  assign cur_grid       = fixed_mode ? low_grid : grid_cnt;
  assign rd_grid        = cmd.accept ? grid_index : cur_grid;
  assign grid_ok        = (32'(grid_index) < GridCount);
  assign rd_byte        = (32'(rd_grid) < GridCount) ? shadow[rd_grid] : 8'h00;
  assign seg_bit        = 8'(1) << segment_index;
  assign edit_byte      = segment_on ? (rd_byte | seg_bit) : (rd_byte & ~seg_bit);
  assign use_fixed      = (dirty_count <= CountW'(fixed_limit)) &&
                          (dirty_count <= lgdr_pkg::FixedCap);
  assign work_mask_next = work_mask & (work_mask - GridCount'(1));

  assign stat.write_req  = (kind == lgdr_pkg::KindFill) ||
                           ((kind == lgdr_pkg::KindTick) && pending);
  assign stat.count_zero = (dirty_count == '0);
  assign stat.seq_done   = fixed_mode ? (work_mask_next == '0)
                                      : (32'(grid_cnt) == GridCount - 1);
  assign stat.fixed      = fixed_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness  <= lgdr_pkg::BrightnessReset;
      fixed_limit <= lgdr_pkg::FixedLimitReset;
    end else if (cfg_we) begin
      case (cfg_index)
        2'(lgdr_pkg::RegBrightness): brightness  <= cfg_data;
        2'(lgdr_pkg::RegFixedLimit): fixed_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < GridCount; g++) begin
        shadow[g] <= 8'h00;
      end
      dirty_mask <= '1;
      pending    <= 1'b1;
      strobe     <= 1'b0;
      fixed_mode <= 1'b0;
      work_mask  <= '0;
      grid_cnt   <= '0;
    end else begin
      strobe <= 1'b0;
      if (cmd.accept) begin
        unique case (kind)
          lgdr_pkg::KindSet: begin
            if (grid_ok) begin
              shadow[grid_index] <= edit_byte;
              if (edit_byte != rd_byte) begin
                pending <= 1'b1;
                dirty_mask[grid_index] <= 1'b1;
              end
            end
          end
          lgdr_pkg::KindTick: begin
            pending <= 1'b0;
          end
          lgdr_pkg::KindFill: begin
            for (int g = 0; g < GridCount; g++) begin
              shadow[g] <= segment_on ? lgdr_pkg::ByteOn : lgdr_pkg::ByteOff;
            end
            dirty_mask <= '1;
          end
          default: ;
        endcase
      end
      unique case (cmd.op)
        lgdr_pkg::OpNone: ;
        lgdr_pkg::OpMode: begin
          if (dirty_count != '0) begin
            fixed_mode   <= use_fixed;
            work_mask    <= dirty_mask;
            dirty_mask   <= '0;
            grid_cnt     <= '0;
            strobe       <= 1'b1;
            bus_byte     <= use_fixed ? lgdr_pkg::CmdFixed : lgdr_pkg::CmdAuto;
            start_before <= 1'b1;
            stop_after   <= 1'b1;
            last         <= 1'b0;
          end
        end
        lgdr_pkg::OpAddr: begin
          strobe       <= 1'b1;
          bus_byte     <= lgdr_pkg::CmdAddr | {5'd0, cur_grid};
          start_before <= 1'b1;
          stop_after   <= 1'b0;
          last         <= 1'b0;
        end
        lgdr_pkg::OpData: begin
          strobe       <= 1'b1;
          bus_byte     <= rd_byte;
          start_before <= 1'b0;
          stop_after   <= fixed_mode | stat.seq_done;
          last         <= 1'b0;
          // advance to the next grid
          if (fixed_mode) begin
            work_mask <= work_mask_next;
          end else begin
            grid_cnt <= grid_cnt + 3'd1;
          end
        end
        lgdr_pkg::OpDisp: begin
          strobe       <= 1'b1;
          bus_byte     <= lgdr_pkg::CmdDispOn | {5'd0, brightness};
          start_before <= 1'b1;
          stop_after   <= 1'b1;
          last         <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/led_grid_dirty_refresh_master_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------------
// item     | start, busy          | kind, grid_index, segment_index, segment_on
// result   | strobe (one cycle)   | bus_byte, start_before, stop_after, last
// config   | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// An item is taken when start is high and busy low. Segment edits and ticks with
// nothing pending are taken without starting a write. A write takes the item,
// then sends its bus beats (up to nine); when nothing is dirty it sends none.
// Beats leave one per cycle from the controller's byte sequencer; the receiver
// cannot stall. Synchronous reset clears the shadow, marks every grid dirty and
// sets the refresh flag. Config writes are taken while busy is low.

module led_grid_dirty_refresh_master_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] kind,
  input  wire logic [2:0] grid_index,
  input  wire logic [2:0] segment_index,
  input  wire logic       segment_on,
  output logic            strobe,
  output logic [7:0]      bus_byte,
  output logic            start_before,
  output logic            stop_after,
  output logic            last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [2:0] cfg_data
);

  lgdr_pkg::lgdr_cmd_t  cmd;
  lgdr_pkg::lgdr_stat_t stat;

  assign cfg_ready = ~busy;

  lgdr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lgdr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .grid_index    (grid_index),
    .segment_index (segment_index),
    .segment_on    (segment_on),
    .strobe        (strobe),
    .bus_byte      (bus_byte),
    .start_before  (start_before),
    .stop_after    (stop_after),
    .last          (last)
  );

endmodule

`default_nettype wire
